### hw/rtl/advf_pkg.sv
package advf_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;
  localparam int ADDR_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NAME_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NAME_SECOND = CFG_IDX_W'(1);

  // AD structure types and the manufacturer pattern
  localparam logic [7:0] TYPE_NAME     = 8'h09;
  localparam logic [7:0] TYPE_MANUF    = 8'hFF;
  localparam logic [7:0] MANUF_LEN     = 8'd5;
  localparam logic [7:0] NAME_MIN_LEN  = 8'd3;
  localparam logic [7:0] MANUF_PAT [4] = '{8'h31, 8'h01, 8'h3b, 8'h04};

  // Highest accepted report type
  localparam logic [2:0] KIND_LAST_ACCEPTED = 3'd4;

  typedef enum logic [2:0] {
    OUT_ADDED    = 3'd0,
    OUT_LISTED   = 3'd1,
    OUT_NO_MATCH = 3'd2,
    OUT_FULL     = 3'd3,
    OUT_IGNORED  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic name_hit;
    logic manuf_hit;
  } parse_status_t;

endpackage

### hw/rtl/advf_in_if.sv
interface advf_in_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 payload_byte;
  logic                       first_of_report;
  logic                       last_of_report;
  logic [2:0]                 event_kind;
  logic [advf_pkg::ADDR_W-1:0] peer_address;

  modport source (output valid, payload_byte, first_of_report, last_of_report,
                  event_kind, peer_address, input ready);
  modport sink   (input valid, payload_byte, first_of_report, last_of_report,
                  event_kind, peer_address, output ready);
endinterface

### hw/rtl/advf_out_if.sv
interface advf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] outcome;
  logic [2:0] slot_index;

  modport source (output valid, outcome, slot_index, input ready);
  modport sink   (input valid, outcome, slot_index, output ready);
endinterface

### hw/rtl/advf_cfg_if.sv
interface advf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [advf_pkg::CFG_IDX_W-1:0]  index;
  logic [advf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/adv_report_device_filter.sv
// A last byte that needs no lookup goes straight to ST_RESULT; otherwise each entry
//   compared passes ST_READ then ST_CMP, and a miss on every counted entry appends in ST_READ.
// Throughput: other bytes one a cycle; a last byte holds the input until its outcome is
//   loaded into the output register, and the lookup reads one table entry per ST_READ/ST_CMP pair.
// Reset (rst_n low, synchronous): clears device count, parse state, name bytes and output
//   valid. Table contents stay undefined; no clearing pass, only counted entries are read.
module adv_report_device_filter #(
  parameter int TABLE_DEPTH = 8,
  parameter int MAX_PAYLOAD = 31
) (
  input logic        clk,
  input logic        rst_n,
  advf_in_if.sink    in_ch,
  advf_out_if.source out_ch,
  advf_cfg_if.sink   cfg_ch
);
  import advf_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]        name_first_r, name_second_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [2:0]        kind_r;
  outcome_t          res_outcome_r, res_outcome_nxt;
  logic [2:0]        res_slot_r, res_slot_nxt;
  logic              out_valid_r;
  outcome_t          out_outcome_r;
  logic [2:0]        out_slot_r;

  logic          in_acc, out_free, addr_hit;
  logic [2:0]    eff_kind;
  parse_status_t status;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign eff_kind     = in_ch.first_of_report ? in_ch.event_kind : kind_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Walk the length-type-data structures of the report
  advf_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .first      (in_ch.first_of_report),
    .last       (in_ch.last_of_report),
    .data_byte  (in_ch.payload_byte),
    .name_first (name_first_r),
    .name_second(name_second_r),
    .status     (status)
  );

  // Found-device table, one read port for the sequential lookup
  advf_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(addr_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared 48-bit comparator
  assign addr_hit = (ram_rdata == addr_r);

  assign ram_waddr = count_r[AW-1:0];
  assign ram_raddr = idx_r[AW-1:0];

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    res_outcome_nxt = res_outcome_r;
    res_slot_nxt    = res_slot_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.last_of_report) begin
          res_slot_nxt = 3'd0;
          idx_nxt      = '0;
          if (count_r == CW'(TABLE_DEPTH)) begin
            res_outcome_nxt = OUT_FULL;
            state_nxt       = ST_RESULT;
          end else if (eff_kind > KIND_LAST_ACCEPTED) begin
            res_outcome_nxt = OUT_IGNORED;
            state_nxt       = ST_RESULT;
          end else if (!(status.name_hit && status.manuf_hit)) begin
            res_outcome_nxt = OUT_NO_MATCH;
            state_nxt       = ST_RESULT;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (idx_r == count_r) begin
          // Not listed: append at the end of the table
          ram_we          = 1'b1;
          count_nxt       = count_r + CW'(1);
          res_outcome_nxt = OUT_ADDED;
          res_slot_nxt    = 3'(idx_r);
          state_nxt       = ST_RESULT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (addr_hit) begin
          res_outcome_nxt = OUT_LISTED;
          res_slot_nxt    = 3'(idx_r);
          state_nxt       = ST_RESULT;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_READ;
        end
      end
      ST_RESULT: begin
        // Hold until the output register frees up
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      idx_r         <= '0;
      kind_r        <= '0;
      addr_r        <= '0;
      name_first_r  <= '0;
      name_second_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      // Sample address and type on the first byte of a report
      if (in_acc && in_ch.first_of_report) begin
        kind_r <= in_ch.event_kind;
        addr_r <= in_ch.peer_address;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_NAME_FIRST:  name_first_r  <= cfg_ch.data;
          REG_NAME_SECOND: name_second_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_outcome_r <= res_outcome_nxt;
    res_slot_r    <= res_slot_nxt;
    if (state_r == ST_RESULT && out_free) begin
      out_outcome_r <= res_outcome_r;
      out_slot_r    <= res_slot_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.outcome    = out_outcome_r;
  assign out_ch.slot_index = out_slot_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("device count beyond table depth");

  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (count_r < CW'(TABLE_DEPTH)))
    else $error("table write while full");

  a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (count_r == $past(count_r) + CW'(1)))
    else $error("table write without count advance");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_of_report) |=> (state_r != ST_IDLE))
    else $error("last byte did not start report finish");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ($past(state_r) == ST_READ))
    else $error("compare without preceding table read");

endmodule

### hw/rtl/advf_ram.sv
module advf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/advf_parser.sv
module advf_parser #(
  parameter int MAX_PAYLOAD = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  first,
  input  logic                  last,
  input  logic [7:0]            data_byte,
  input  logic [7:0]            name_first,
  input  logic [7:0]            name_second,
  output advf_pkg::parse_status_t status
);
  import advf_pkg::*;

  localparam int PW = $clog2(MAX_PAYLOAD + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [8:0]    start_r, start_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [1:0]    flags_r, flags_nxt;
  logic          fin_r, fin_nxt;
  logic          ok_r, ok_nxt;

  // Current state as seen by this byte: a first mark restarts the report
  logic [PW-1:0] c_pos;
  logic [8:0]    c_start;
  logic [7:0]    c_len, c_type;
  logic [1:0]    c_flags;
  logic          c_fin, c_ok;
  logic [9:0]    p10, s10, end_cur, end_new, d10;
  logic          active;

  always_comb begin
    if (first) begin
      c_pos = '0; c_start = '0; c_len = '0; c_type = '0;
      c_flags = '0; c_fin = 1'b0; c_ok = 1'b0;
    end else begin
      c_pos = pos_r; c_start = start_r; c_len = len_r; c_type = type_r;
      c_flags = flags_r; c_fin = fin_r; c_ok = ok_r;
    end

    pos_nxt = c_pos; start_nxt = c_start; len_nxt = c_len; type_nxt = c_type;
    flags_nxt = c_flags; fin_nxt = c_fin; ok_nxt = c_ok;

    active  = !c_fin && (c_pos < PW'(MAX_PAYLOAD));
    p10     = 10'(c_pos);
    s10     = 10'(c_start);
    end_cur = s10 + 10'(c_len);
    d10     = p10 - s10 - 10'd2;
    end_new = '0;

    if (active) begin
      if (p10 == s10) begin
        len_nxt = data_byte;
      end else if (p10 == s10 + 10'd1) begin
        type_nxt = data_byte;
        ok_nxt   = 1'b1;
      end else if (p10 <= end_cur) begin
        if (c_type == TYPE_NAME && c_len > NAME_MIN_LEN) begin
          if (d10 == 10'd0) begin
            ok_nxt = (data_byte == name_first);
          end else if (d10 == 10'd1 && c_ok && data_byte == name_second) begin
            flags_nxt[0] = 1'b1;
          end
        end else if (c_type == TYPE_MANUF && c_len == MANUF_LEN) begin
          if (d10 < 10'd4) begin
            ok_nxt = c_ok && (data_byte == MANUF_PAT[d10[1:0]]);
            if (d10 == 10'd3 && ok_nxt) begin
              flags_nxt[1] = 1'b1;
            end
          end
        end
      end
      // Advance to the next structure once the current one ends
      end_new = s10 + 10'(len_nxt);
      if (p10 == end_new) begin
        start_nxt = 9'(end_new + 10'd1);
      end
      if (flags_nxt == 2'b11) begin
        fin_nxt = 1'b1;
      end
    end

    if (c_pos < PW'(MAX_PAYLOAD)) begin
      pos_nxt = c_pos + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      pos_r <= '0; start_r <= '0; len_r <= '0; type_r <= '0;
      flags_r <= '0; fin_r <= 1'b0; ok_r <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt; start_r <= start_nxt; len_r <= len_nxt;
      type_r <= type_nxt; flags_r <= flags_nxt; fin_r <= fin_nxt;
      ok_r <= ok_nxt;
    end
  end

  assign status.name_hit  = flags_nxt[0];
  assign status.manuf_hit = flags_nxt[1];

endmodule

### tb/tb_adv_report_device_filter.sv
`timescale 1ns / 1ps

module tb_adv_report_device_filter;
  import advf_pkg::*;

  localparam int TABLE_DEPTH     = 8;
  localparam int MAX_PAYLOAD     = 31;
  // Watchdog limit, with ample margin over the slowest run.
  localparam int CYCLE_LIMIT     = 300000;
  // Settle time for wait_idle, with margin over the longest table lookup.
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_BYTES     = 190;

  // One input transaction, plus an optional hand-typed expected outcome.
  typedef struct packed {
    logic [7:0]        pbyte;
    logic              first;
    logic              last;
    logic [2:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic              typed;
    outcome_t          oc;
    logic [2:0]        slot;
  } adv_byte_t;

  typedef struct packed {
    outcome_t   oc;
    logic [2:0] slot;
  } outcome_rec_t;

  logic clk;
  logic rst_n;

  advf_in_if  in_ch ();
  advf_out_if out_ch ();
  advf_cfg_if cfg_ch ();

  adv_report_device_filter #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of configuration, device table and parse state.
  // ---------------------------------------------------------------------------
  logic [7:0]        want_first_char  = '0;
  logic [7:0]        want_second_char = '0;
  int unsigned       dev_count        = 0;
  logic [ADDR_W-1:0] dev_table [TABLE_DEPTH];
  int                pos              = 0;
  int                st_start         = 0;
  int                st_len           = 0;
  int                st_type          = 0;
  parse_status_t     hits             = '0;
  bit                parse_done       = 1'b0;
  bit                data_ok          = 1'b0;
  logic [ADDR_W-1:0] rpt_addr         = '0;
  logic [2:0]        rpt_kind         = '0;

  outcome_rec_t pending_outcomes [$];
  int           mismatches = 0;
  int           bytes_sent = 0;
  int           cycle_count = 0;

  // Stimulus knobs, written by the main sequence only.
  bit idle_on      = 1'b0;
  bit hold_off_req = 1'b0;

  task automatic clear_parse();
    pos        = 0;
    st_start   = 0;
    st_len     = 0;
    st_type    = 0;
    hits       = '0;
    parse_done = 1'b0;
    data_ok    = 1'b0;
  endtask

  // Advance the predictor by one accepted byte; return the outcome on a last byte.
  task automatic track_report_byte(input adv_byte_t it, output bit has_result,
                                   output outcome_rec_t res);
    int d;
    int i;
    has_result = 1'b0;
    res.oc     = OUT_NO_MATCH;
    res.slot   = '0;
    if (it.first) begin
      clear_parse();
      rpt_kind = it.kind;
      rpt_addr = it.addr;
    end
    // Bytes past the payload limit, or after both hits, are not parsed.
    if (!parse_done && pos < MAX_PAYLOAD) begin
      if (pos == st_start) begin
        st_len = it.pbyte;
      end else if (pos == st_start + 1) begin
        st_type = it.pbyte;
        data_ok = 1'b1;
      end else if (pos <= st_start + st_len) begin
        d = pos - st_start - 2;
        if (st_type == TYPE_NAME && st_len > NAME_MIN_LEN) begin
          if (d == 0)
            data_ok = (it.pbyte == want_first_char);
          else if (d == 1 && data_ok && it.pbyte == want_second_char)
            hits.name_hit = 1'b1;
        end else if (st_type == TYPE_MANUF && st_len == MANUF_LEN) begin
          if (d < 4) begin
            data_ok = data_ok && (it.pbyte == MANUF_PAT[d]);
            if (d == 3 && data_ok)
              hits.manuf_hit = 1'b1;
          end
        end
      end
      // A zero-length structure ends on its own length byte.
      if (pos == st_start + st_len)
        st_start = (st_start + st_len + 1) & 'h1FF;
      if (hits == 2'b11)
        parse_done = 1'b1;
    end
    if (pos < MAX_PAYLOAD)
      pos++;
    if (it.last) begin
      has_result = 1'b1;
      if (dev_count >= TABLE_DEPTH) begin
        res.oc = OUT_FULL;
      end else if (rpt_kind > KIND_LAST_ACCEPTED) begin
        res.oc = OUT_IGNORED;
      end else if (hits != 2'b11) begin
        res.oc = OUT_NO_MATCH;
      end else begin
        res.oc = OUT_ADDED;
        for (i = 0; i < dev_count && res.oc == OUT_ADDED; i++) begin
          if (dev_table[i] == rpt_addr) begin
            res.oc   = OUT_LISTED;
            res.slot = 3'(i);
          end
        end
        if (res.oc == OUT_ADDED) begin
          res.slot             = 3'(dev_count);
          dev_table[dev_count] = rpt_addr;
          dev_count++;
        end
      end
      clear_parse();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic check_outcome();
    outcome_rec_t want;
    if (pending_outcomes.size() == 0) begin
      report_mismatch("outcome with none pending", int'(out_ch.outcome), -1);
    end else begin
      want = pending_outcomes.pop_front();
      if (out_ch.outcome !== want.oc)
        report_mismatch("outcome", int'(out_ch.outcome), int'(want.oc));
      if (out_ch.slot_index !== want.slot)
        report_mismatch("slot_index", int'(out_ch.slot_index), int'(want.slot));
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int gap_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: sample at the edge, then pick next cycle's ready.
  // ---------------------------------------------------------------------------
  int unsigned rx_stall       = 0;
  bit          hold_off_taken = 1'b0;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      check_outcome();
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_req && !hold_off_taken) begin
      // Hold off once for a long stretch so the block fills and stalls its input.
      hold_off_taken <= 1'b1;
      rx_stall       <= HOLD_OFF_CYCLES;
      out_ch.ready   <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall     <= rx_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      rx_stall     <= gap_cycles() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one byte, hold it until the transaction completes, predict, then
  // maybe idle. Valid stays high into the next byte when no gap is taken.
  task automatic send_byte(input adv_byte_t it);
    bit           has_result;
    outcome_rec_t res;
    in_ch.valid           <= 1'b1;
    in_ch.payload_byte    <= it.pbyte;
    in_ch.first_of_report <= it.first;
    in_ch.last_of_report  <= it.last;
    in_ch.event_kind      <= it.kind;
    in_ch.peer_address    <= it.addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_report_byte(it, has_result, res);
    if (has_result) begin
      if (it.typed) begin
        res.oc   = it.oc;
        res.slot = it.slot;
      end
      pending_outcomes.push_back(res);
    end
    bytes_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_cycles()) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every pending outcome, then let the lookup settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both name registers; call only while the block is idle.
  task automatic write_names(input logic [7:0] first_char, input logic [7:0] second_char);
    int i;
    for (i = 0; i < 2; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= (i == 0) ? REG_NAME_FIRST : REG_NAME_SECOND;
      cfg_ch.data  <= (i == 0) ? first_char : second_char;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid     <= 1'b0;
    want_first_char  = first_char;
    want_second_char = second_char;
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // ---------------------------------------------------------------------------
  // Report generation
  // ---------------------------------------------------------------------------
  logic [7:0]        adv_payload [$];
  logic [ADDR_W-1:0] addr_pool [12];

  // Build one report into adv_payload: noise, or a name and a manufacturer
  // structure mixed with filler, mostly well-formed, sometimes cut short or with trailing junk.
  task automatic build_report(input bit noise);
    int parts [$];
    int len;
    int j;
    logic [7:0] b;
    adv_payload.delete();
    if (noise) begin
      repeat ($urandom_range(1, 40)) adv_payload.push_back(8'($urandom));
      return;
    end
    parts = '{0, 1};
    repeat ($urandom_range(0, 2))
      parts.insert($urandom_range(0, parts.size()), $urandom_range(2, 3));
    foreach (parts[k]) begin
      case (parts[k])
        0: begin
          // Complete name; lengths up to 3 can never hit.
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 6);
          adv_payload.push_back(8'(len));
          adv_payload.push_back(TYPE_NAME);
          for (j = 0; j < len - 1; j++) begin
            b = 8'($urandom);
            if (j == 0 && $urandom_range(0, 6) != 0) b = want_first_char;
            if (j == 1 && $urandom_range(0, 6) != 0) b = want_second_char;
            adv_payload.push_back(b);
          end
        end
        1: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 7) : int'(MANUF_LEN);
          adv_payload.push_back(8'(len));
          adv_payload.push_back(TYPE_MANUF);
          for (j = 0; j < len - 1; j++) begin
            b = 8'($urandom);
            if (j < 4 && $urandom_range(0, 19) != 0) b = MANUF_PAT[j];
            adv_payload.push_back(b);
          end
        end
        2: adv_payload.push_back(8'h00);
        default: begin
          // Other structure; a long one pushes later ones past the payload limit.
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
          adv_payload.push_back(8'(len));
          adv_payload.push_back(8'($urandom));
          repeat (len - 1) adv_payload.push_back(8'($urandom));
        end
      endcase
    end
    // Cut the last structure short now and then, or add trailing junk.
    if ($urandom_range(0, 6) == 0 && adv_payload.size() > 3)
      repeat ($urandom_range(1, 3)) void'(adv_payload.pop_back());
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) adv_payload.push_back(8'($urandom));
  endtask

  // Send the first n bytes of adv_payload. Kind and address are random on
  // bytes that carry no first mark, since the block must ignore them there.
  task automatic send_report(input int n, input bit mark_first, input bit mark_last,
                             input logic [2:0] kind, input logic [ADDR_W-1:0] addr);
    adv_byte_t it;
    int i;
    for (i = 0; i < n; i++) begin
      it       = '0;
      it.pbyte = adv_payload[i];
      it.first = (i == 0) && mark_first;
      it.last  = (i == n - 1) && mark_last;
      it.kind  = it.first ? kind : 3'($urandom);
      it.addr  = it.first ? addr : rand_addr();
      send_byte(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed bytes, sent with names FF / 00.
  // ---------------------------------------------------------------------------
  localparam adv_byte_t DIRECTED_BYTES [21] = '{
    // One-byte report, ignored event type, all-ones address
    '{8'hFF, 1'b1, 1'b1, 3'd7, 48'hFFFF_FFFF_FFFF, 1'b1, OUT_IGNORED, 3'd0},
    // One-byte report, accepted type, nothing found
    '{8'h00, 1'b1, 1'b1, 3'd0, 48'h0, 1'b1, OUT_NO_MATCH, 3'd0},
    // Zero-length structure, name FF 00 .., manufacturer pattern, then a byte
    // after both hits that must be ignored; address all zeros
    '{8'h00, 1'b1, 1'b0, 3'd4, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h04, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h09, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h00, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h41, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h05, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h31, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h01, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h3b, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h04, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'h77, 1'b0, 1'b1, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    // Last byte with no first mark: new report reusing kind and address
    '{8'h00, 1'b0, 1'b1, 3'd7, 48'hFFFF_FFFF_FFFF, 1'b1, OUT_NO_MATCH, 3'd0},
    // First mark inside a report: the abandoned one gives nothing
    '{8'h05, 1'b1, 1'b0, 3'd1, 48'h1234_5678_9ABC, 1'b0, OUT_ADDED, 3'd0},
    '{8'h09, 1'b1, 1'b1, 3'd2, 48'h8000_0000_0001, 1'b1, OUT_NO_MATCH, 3'd0},
    // Name structure cut off by the report end
    '{8'h05, 1'b1, 1'b0, 3'd3, 48'hFFFF_FFFF_FFFF, 1'b0, OUT_ADDED, 3'd0},
    '{8'h09, 1'b0, 1'b0, 3'd0, 48'h0, 1'b0, OUT_ADDED, 3'd0},
    '{8'hFF, 1'b0, 1'b1, 3'd0, 48'h0, 1'b1, OUT_NO_MATCH, 3'd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int         target;
    int         pool_top;
    int         style;
    int         k;
    logic [2:0] kind;
    logic [7:0] name_a;
    logic [7:0] name_b;

    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.payload_byte    = '0;
    in_ch.first_of_report = 1'b0;
    in_ch.last_of_report  = 1'b0;
    in_ch.event_kind      = '0;
    in_ch.peer_address    = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;

    // Address pool: extremes, random ones, and near misses of random ones
    // (one byte flipped, one byte cleared, one bit flipped).
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (k = 2; k < 8; k++) addr_pool[k] = rand_addr();
    addr_pool[8]  = addr_pool[2] ^ (48'hFF << (8 * $urandom_range(0, 5)));
    addr_pool[9]  = addr_pool[3] & ~(48'hFF << (8 * $urandom_range(0, 5)));
    addr_pool[10] = addr_pool[4] ^ (48'h1 << $urandom_range(0, 47));
    addr_pool[11] = addr_pool[5] ^ (48'hFF << (8 * $urandom_range(0, 5)));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_names(8'hFF, 8'h00);
    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
    wait_idle();

    // Random phases: new names each time; the table grows as the pool widens.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          name_a = 8'h00;
          name_b = 8'h00;
        end
        1: begin
          name_a = 8'hFF;
          name_b = 8'hFF;
        end
        default: begin
          name_a = 8'($urandom);
          name_b = 8'($urandom);
        end
      endcase
      write_names(name_a, name_b);
      // Phase 1 runs with no idling on either side, plus the long hold-off.
      idle_on <= (ph != 1);
      if (ph == 1)
        hold_off_req <= 1'b1;
      pool_top = (ph == 0) ? 3 : (ph == 1) ? 5 : 11;
      target   = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        kind  = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
        style = $urandom_range(0, 9);
        if (style <= 6) begin
          build_report(1'b0);
          send_report(adv_payload.size(), 1'b1, 1'b1, kind,
                      addr_pool[$urandom_range(0, pool_top)]);
        end else if (style == 7) begin
          build_report(1'b1);
          send_report(adv_payload.size(), 1'b1, 1'b1, kind, rand_addr());
        end else if (style == 8) begin
          // Abandon a report part way, then send a whole one.
          build_report(1'b0);
          send_report($urandom_range(1, adv_payload.size()), 1'b1, 1'b0, kind, rand_addr());
          build_report(1'b0);
          send_report(adv_payload.size(), 1'b1, 1'b1, kind,
                      addr_pool[$urandom_range(0, pool_top)]);
        end else begin
          // Report with no first mark: reuses the previous kind and address.
          build_report(1'b0);
          send_report(adv_payload.size(), 1'b0, 1'b1, kind, rand_addr());
        end
      end
      wait_idle();
    end

    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
